FILE: rtl/core/pvc_pkg.sv
// Shared types and constants for the PI velocity controller.
// Used by pvc_mul, pvc_seq and pi_velocity_control_with_drive_top; no dependencies.
package pvc_pkg;

   localparam int VEL_W     = 16;            // velocity field width
   localparam int ERR_W     = VEL_W + 1;     // reference minus measurement
   localparam int GAIN_W    = 16;            // Q8.8 gains and Q0.16 period
   localparam int LIMIT_W   = 8;             // integral clamp, whole counts
   localparam int INT_W     = 25;            // integral, Q.16
   localparam int OPND_W    = 25;            // signed multiplier operand
   localparam int PROD_W    = GAIN_W + 1 + OPND_W;
   localparam int SUM_W     = 35;            // integral plus period product
   localparam int DRV_W     = 52;            // Q.24 drive accumulator
   localparam int MAG_W     = 12;            // magnitude field width
   localparam int ABS_W     = DRV_W - 1;
   localparam int FRAC_W    = 24;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 16;

   localparam int PWM_MAX = 4095;
   localparam logic [ABS_W-1:0] SAT_THRESH = ABS_W'(PWM_MAX) << FRAC_W;
   localparam logic [ABS_W-1:0] ROUND_HALF = ABS_W'(1) << (FRAC_W - 1);

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] REG_FF_GAIN  = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_P_GAIN   = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_I_GAIN   = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_PERIOD   = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_I_LIMIT  = 3'd4;

   // reset values
   localparam logic [GAIN_W-1:0]  RST_FF_GAIN = 16'd1667;
   localparam logic [GAIN_W-1:0]  RST_P_GAIN  = 16'd2458;
   localparam logic [GAIN_W-1:0]  RST_I_GAIN  = 16'd12288;
   localparam logic [GAIN_W-1:0]  RST_PERIOD  = 16'd655;
   localparam logic [LIMIT_W-1:0] RST_I_LIMIT = 8'd80;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_INT,
      ST_CLAMP,
      ST_ACC_FF,
      ST_ACC_P,
      ST_ACC_I,
      ST_ABS,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      MS_PERIOD,
      MS_FF,
      MS_PROP,
      MS_INT
   } mul_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_LOAD_SHIFT,
      ACC_ADD_SHIFT,
      ACC_ADD
   } acc_op_type;

   typedef struct packed {
      logic        load_req;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        int_load;
      acc_op_type  acc_op;
      logic        mag_load;
      logic        rsp_load;
   } ctrl_type;

endpackage

FILE: rtl/core/pi_velocity_control_with_drive_top.sv
// Top level of the PI velocity controller: registers, datapath and stream ports.
// Depends on pvc_pkg, pvc_mul and pvc_seq.
//
// Usage:
//   A request on req_* carries a velocity reference and a measured velocity.
//   The block forms the error, updates the clamped integral and sums the
//   feedforward, proportional and integral terms, then returns one response
//   on rsp_*: direction, rounded and saturated magnitude, saturation flag.
//   One multiplier is shared over four products, so a request occupies the
//   block until its response is loaded, and no new request is taken before
//   then, even with no back-pressure.
//   req_tready is high whenever the sequencer is idle, also while a previous
//   response still waits in the output register.
//   If rsp_tready stays low, the finished request waits in its last step
//   until the output register frees, and no new request is taken meanwhile.
//   Registers must be written by the user through csr_* while the block is idle; not enforced.
//   Reset (synchronous) restores the register defaults, clears the integral
//   and drops rsp_tvalid.
module pi_velocity_control_with_drive_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [31:0]                        req_tdata,  // velocity_reference, measured_velocity
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [15:0]                        rsp_tdata,  // forward, pwm_magnitude, drive_saturated
   input  logic                               csr_we,
   input  logic [pvc_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [pvc_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   pvc_pkg::ctrl_type ctrl;
   logic              idle;
   logic              req_fire;
   logic              out_free;

   logic [pvc_pkg::GAIN_W-1:0]  ff_gain_ff, p_gain_ff, i_gain_ff, period_ff;
   logic [pvc_pkg::LIMIT_W-1:0] i_limit_ff;

   logic signed [pvc_pkg::VEL_W-1:0]  ref_ff;
   logic signed [pvc_pkg::ERR_W-1:0]  err_ff;
   logic signed [pvc_pkg::ERR_W-1:0]  err_in;
   logic signed [pvc_pkg::INT_W-1:0]  integral_ff;
   logic signed [pvc_pkg::INT_W-1:0]  integral_in;
   logic signed [pvc_pkg::DRV_W-1:0]  drive_ff;
   logic signed [pvc_pkg::DRV_W-1:0]  drive_in;
   logic        [pvc_pkg::ABS_W-1:0]  mag_ff;
   logic        [pvc_pkg::ABS_W-1:0]  mag_in;
   logic                              fwd_ff;

   logic                              rsp_valid_ff;
   logic                              rsp_fwd_ff, rsp_sat_ff;
   logic [pvc_pkg::MAG_W-1:0]         rsp_mag_ff;

   logic        [pvc_pkg::GAIN_W-1:0] mul_gain;
   logic signed [pvc_pkg::OPND_W-1:0] mul_opnd;
   logic signed [pvc_pkg::PROD_W-1:0] prod;

   logic signed [pvc_pkg::SUM_W-1:0]  sum;
   logic signed [pvc_pkg::SUM_W-1:0]  lim_pos;
   logic signed [pvc_pkg::SUM_W-1:0]  lim_neg;
   logic signed [pvc_pkg::SUM_W-1:0]  clamped;
   logic                              sat;
   logic        [pvc_pkg::ABS_W-1:0]  rounded;
   logic        [pvc_pkg::MAG_W-1:0]  mag_out;

   assign req_tready = idle;
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   pvc_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .req_fire (req_fire),
      .out_free (out_free),
      .idle     (idle),
      .ctrl     (ctrl)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ff_gain_ff <= pvc_pkg::RST_FF_GAIN;
         p_gain_ff  <= pvc_pkg::RST_P_GAIN;
         i_gain_ff  <= pvc_pkg::RST_I_GAIN;
         period_ff  <= pvc_pkg::RST_PERIOD;
         i_limit_ff <= pvc_pkg::RST_I_LIMIT;
      end else if (csr_we) begin
         unique case (csr_addr)
            pvc_pkg::REG_FF_GAIN: ff_gain_ff <= csr_wdata;
            pvc_pkg::REG_P_GAIN:  p_gain_ff  <= csr_wdata;
            pvc_pkg::REG_I_GAIN:  i_gain_ff  <= csr_wdata;
            pvc_pkg::REG_PERIOD:  period_ff  <= csr_wdata;
            pvc_pkg::REG_I_LIMIT: i_limit_ff <= csr_wdata[pvc_pkg::LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   // request capture
   assign err_in = $signed({req_tdata[15], req_tdata[15:0]})
                 - $signed({req_tdata[31], req_tdata[31:16]});

   always_ff @(posedge clock) begin
      if (ctrl.load_req) begin
         ref_ff <= $signed(req_tdata[15:0]);
         err_ff <= err_in;
      end
   end

   // operand selection for the shared multiplier
   always_comb begin
      case (ctrl.mul_sel)
         pvc_pkg::MS_PERIOD: begin
            mul_gain = period_ff;
            mul_opnd = pvc_pkg::OPND_W'(err_ff);
         end
         pvc_pkg::MS_FF: begin
            mul_gain = ff_gain_ff;
            mul_opnd = pvc_pkg::OPND_W'(ref_ff);
         end
         pvc_pkg::MS_PROP: begin
            mul_gain = p_gain_ff;
            mul_opnd = pvc_pkg::OPND_W'(err_ff);
         end
         default: begin
            mul_gain = i_gain_ff;
            mul_opnd = integral_ff;
         end
      endcase
   end

   pvc_mul u_mul (
      .clock (clock),
      .en    (ctrl.mul_en),
      .gain  (mul_gain),
      .opnd  (mul_opnd),
      .prod  (prod)
   );

   // integral update with symmetric clamp
   assign sum     = pvc_pkg::SUM_W'(integral_ff) + prod[pvc_pkg::SUM_W-1:0];
   assign lim_pos = $signed({11'd0, i_limit_ff, 16'd0});
   assign lim_neg = -lim_pos;

   always_comb begin
      if (sum > lim_pos) begin
         clamped = lim_pos;
      end else if (sum < lim_neg) begin
         clamped = lim_neg;
      end else begin
         clamped = sum;
      end
   end

   assign integral_in = clamped[pvc_pkg::INT_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         integral_ff <= '0;
      end else if (ctrl.int_load) begin
         integral_ff <= integral_in;
      end
   end

   // Q.24 drive accumulation; gain times velocity terms are shifted up by 16
   always_comb begin
      case (ctrl.acc_op)
         pvc_pkg::ACC_LOAD_SHIFT: drive_in = $signed({prod[35:0], 16'd0});
         pvc_pkg::ACC_ADD_SHIFT:  drive_in = drive_ff + $signed({prod[35:0], 16'd0});
         pvc_pkg::ACC_ADD:        drive_in = drive_ff + pvc_pkg::DRV_W'(prod);
         default:                 drive_in = drive_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      drive_ff <= drive_in;
   end

   // sign and magnitude
   assign mag_in = drive_ff[pvc_pkg::DRV_W-1] ? pvc_pkg::ABS_W'(-drive_ff)
                                              : drive_ff[pvc_pkg::ABS_W-1:0];

   always_ff @(posedge clock) begin
      if (ctrl.mag_load) begin
         mag_ff <= mag_in;
         fwd_ff <= ~drive_ff[pvc_pkg::DRV_W-1];
      end
   end

   // round half away from zero, saturate on the exact value
   assign sat     = mag_ff > pvc_pkg::SAT_THRESH;
   assign rounded = mag_ff + pvc_pkg::ROUND_HALF;
   assign mag_out = sat ? pvc_pkg::MAG_W'(pvc_pkg::PWM_MAX)
                        : rounded[pvc_pkg::FRAC_W +: pvc_pkg::MAG_W];

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.rsp_load) begin
         rsp_fwd_ff <= fwd_ff;
         rsp_mag_ff <= mag_out;
         rsp_sat_ff <= sat;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_sat_ff, rsp_mag_ff, rsp_fwd_ff};

endmodule

FILE: rtl/core/pvc_mul.sv
// Shared multiplier: unsigned gain times signed operand, product registered.
// Depends on pvc_pkg.
module pvc_mul (
   input  logic                                 clock,
   input  logic                                 en,
   input  logic        [pvc_pkg::GAIN_W-1:0]    gain,
   input  logic signed [pvc_pkg::OPND_W-1:0]    opnd,
   output logic signed [pvc_pkg::PROD_W-1:0]    prod
);

   logic signed [pvc_pkg::PROD_W-1:0] prod_ff;
   logic signed [pvc_pkg::PROD_W-1:0] prod_in;

   assign prod_in = $signed({1'b0, gain}) * opnd;

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

FILE: rtl/core/pvc_seq.sv
// Sequencer stepping one request through the shared multiplier.
// Depends on pvc_pkg.
module pvc_seq (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_fire,
   input  logic               out_free,
   output logic               idle,
   output pvc_pkg::ctrl_type  ctrl
);

   pvc_pkg::state_type state_ff;
   pvc_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pvc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pvc_pkg::ST_IDLE:    if (req_fire) state_in = pvc_pkg::ST_MUL_INT;
         pvc_pkg::ST_MUL_INT: state_in = pvc_pkg::ST_CLAMP;
         pvc_pkg::ST_CLAMP:   state_in = pvc_pkg::ST_ACC_FF;
         pvc_pkg::ST_ACC_FF:  state_in = pvc_pkg::ST_ACC_P;
         pvc_pkg::ST_ACC_P:   state_in = pvc_pkg::ST_ACC_I;
         pvc_pkg::ST_ACC_I:   state_in = pvc_pkg::ST_ABS;
         pvc_pkg::ST_ABS:     state_in = pvc_pkg::ST_OUT;
         pvc_pkg::ST_OUT:     if (out_free) state_in = pvc_pkg::ST_IDLE;
         default:             state_in = pvc_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl          = '0;
      ctrl.mul_sel  = pvc_pkg::MS_PERIOD;
      ctrl.acc_op   = pvc_pkg::ACC_HOLD;
      idle          = 1'b0;
      unique case (state_ff)
         pvc_pkg::ST_IDLE: begin
            idle          = 1'b1;
            ctrl.load_req = req_fire;
         end
         pvc_pkg::ST_MUL_INT: begin
            ctrl.mul_en  = 1'b1;
            ctrl.mul_sel = pvc_pkg::MS_PERIOD;
         end
         pvc_pkg::ST_CLAMP: begin
            ctrl.int_load = 1'b1;
            ctrl.mul_en   = 1'b1;
            ctrl.mul_sel  = pvc_pkg::MS_FF;
         end
         pvc_pkg::ST_ACC_FF: begin
            ctrl.acc_op  = pvc_pkg::ACC_LOAD_SHIFT;
            ctrl.mul_en  = 1'b1;
            ctrl.mul_sel = pvc_pkg::MS_PROP;
         end
         pvc_pkg::ST_ACC_P: begin
            ctrl.acc_op  = pvc_pkg::ACC_ADD_SHIFT;
            ctrl.mul_en  = 1'b1;
            ctrl.mul_sel = pvc_pkg::MS_INT;
         end
         pvc_pkg::ST_ACC_I: ctrl.acc_op   = pvc_pkg::ACC_ADD;
         pvc_pkg::ST_ABS:   ctrl.mag_load = 1'b1;
         pvc_pkg::ST_OUT:   ctrl.rsp_load = out_free;
         default: ;
      endcase
   end

endmodule

FILE: tb/testbench.sv
// Self-checking bench for pi_velocity_control_with_drive_top: drives control ticks on req_*,
// predicts direction, magnitude and saturation in-bench and checks every rsp_* result.
// Depends on pvc_pkg and the top-level RTL only.
module testbench;

   localparam int HALF_PERIOD = 10;
   localparam int DRAIN_CYCLES = 12;   // drain wait, longer than one request's occupancy of the block
   localparam int STALL_LIMIT = 4000;
   localparam int REPORT_MAX = 10;

   typedef struct packed {
      logic                      forward;
      logic [pvc_pkg::MAG_W-1:0] magnitude;
      logic                      saturated;
   } drive_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [31:0]                    req_tdata = '0;   // velocity_reference, measured_velocity
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [15:0]                    rsp_tdata;        // forward, pwm_magnitude, drive_saturated
   logic                           csr_we = 1'b0;
   logic [pvc_pkg::CSR_ADDR_W-1:0] csr_addr = '0;
   logic [pvc_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   // bench copy of the controller registers and integral
   logic [pvc_pkg::GAIN_W-1:0]  gain_ff, gain_p, gain_i, period_q16;
   logic [pvc_pkg::LIMIT_W-1:0] limit_counts;
   longint                      integral_q16;

   drive_type pending_drive[$];
   bit     idle_on = 1'b1;
   int     mismatches = 0;
   int     ticks_sent = 0;
   int     saturated_seen = 0;
   int     settings_used = 0;
   int     quiet_cycles = 0;

   pi_velocity_control_with_drive_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #HALF_PERIOD clock = ~clock;

   // one control tick: update the clamped integral and form the Q.24 drive
   function automatic drive_type control_tick(
         input logic signed [pvc_pkg::VEL_W-1:0] vref,
         input logic signed [pvc_pkg::VEL_W-1:0] vmeas);
      longint r, m, e, lim, acc, drv, mag_abs;
      drive_type res;
      r = vref;
      m = vmeas;
      e = r - m;
      lim = longint'(limit_counts) * 65536;
      acc = integral_q16 + e * longint'(period_q16);
      if (acc > lim) acc = lim;
      if (acc < -lim) acc = -lim;
      integral_q16 = acc;
      drv = longint'(gain_ff) * r * 65536 + longint'(gain_p) * e * 65536
          + longint'(gain_i) * acc;
      res.forward = (drv >= 0);
      mag_abs = res.forward ? drv : -drv;
      res.saturated = (mag_abs > (longint'(pvc_pkg::PWM_MAX) << pvc_pkg::FRAC_W));
      if (res.saturated)
         res.magnitude = pvc_pkg::MAG_W'(pvc_pkg::PWM_MAX);
      else
         res.magnitude = pvc_pkg::MAG_W'((mag_abs + (64'sd1 << (pvc_pkg::FRAC_W - 1)))
                                         >>> pvc_pkg::FRAC_W);
      return res;
   endfunction

   task automatic write_reg(input logic [pvc_pkg::CSR_ADDR_W-1:0] idx,
                            input logic [pvc_pkg::CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      case (idx)
         pvc_pkg::REG_FF_GAIN: gain_ff = val;
         pvc_pkg::REG_P_GAIN:  gain_p = val;
         pvc_pkg::REG_I_GAIN:  gain_i = val;
         pvc_pkg::REG_PERIOD:  period_q16 = val;
         pvc_pkg::REG_I_LIMIT: limit_counts = val[pvc_pkg::LIMIT_W-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic send_request(input logic signed [pvc_pkg::VEL_W-1:0] vref,
                               input logic signed [pvc_pkg::VEL_W-1:0] vmeas);
      drive_type res;
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {vmeas, vref};
      do @(posedge clock); while (!req_tready);
      res = control_tick(vref, vmeas);
      if (res.saturated) saturated_seen++;
      pending_drive.push_back(res);
      ticks_sent++;
   endtask

   // drop valid, let every result come back and the sequencer go idle
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_drive.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic apply_setting(input logic [15:0] ff, input logic [15:0] p,
                                input logic [15:0] i, input logic [15:0] per,
                                input logic [15:0] lim);
      settle();
      write_reg(pvc_pkg::REG_FF_GAIN, ff);
      write_reg(pvc_pkg::REG_P_GAIN, p);
      write_reg(pvc_pkg::REG_I_GAIN, i);
      write_reg(pvc_pkg::REG_PERIOD, per);
      write_reg(pvc_pkg::REG_I_LIMIT, lim);
      settings_used++;
   endtask

   function automatic logic [15:0] pick_gain();
      case ($urandom_range(0, 5))
         0: return 16'd0;
         1: return 16'hFFFF;
         2, 3: return 16'($urandom_range(0, 1024));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic signed [pvc_pkg::VEL_W-1:0] pick_velocity();
      case ($urandom_range(0, 9))
         0: return pvc_pkg::VEL_W'($urandom);
         1: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
         2: return pvc_pkg::VEL_W'($signed($urandom_range(0, 120)) - 60);
         default: return pvc_pkg::VEL_W'($signed($urandom_range(0, 3000)) - 1500);
      endcase
   endfunction

   // mostly runs of same-signed error to wind the integral into its clamp,
   // with unrelated random pairs mixed in
   task automatic random_ticks(input int count);
      logic signed [pvc_pkg::VEL_W-1:0] vref, vmeas;
      int bias;
      int run_left;
      bias = 0;
      run_left = 0;
      for (int n = 0; n < count; n++) begin
         if (run_left == 0) begin
            run_left = $urandom_range(3, 20);
            bias = $signed($urandom_range(0, 400)) - 200;
         end
         run_left--;
         vref = pick_velocity();
         if ($urandom_range(0, 3) == 0)
            vmeas = pick_velocity();
         else
            vmeas = vref - pvc_pkg::VEL_W'(bias)
                  + pvc_pkg::VEL_W'($signed($urandom_range(0, 20)) - 10);
         send_request(vref, vmeas);
         if ($urandom_range(0, 99) == 0) settle();
      end
   endtask

   task automatic test_reset_defaults();
      send_request(16'sd0, 16'sd0);
      send_request(16'sd100, 16'sd90);
      send_request(-16'sd100, -16'sd95);
      send_request(16'sh7FFF, 16'sh8000);
      send_request(16'sh8000, 16'sh7FFF);
      send_request(16'sh8000, 16'sh8000);
      send_request(16'sh7FFF, 16'sh7FFF);
   endtask

   task automatic test_drive_edges();
      // unity feedforward only: drive equals the reference exactly
      apply_setting(16'd256, 16'd0, 16'd0, 16'd0, 16'd0);
      send_request(16'sd4095, 16'sd0);      // exactly at the maximum, not clipped
      send_request(16'sd4096, 16'sd7);      // just above
      send_request(-16'sd4095, 16'sd0);
      send_request(-16'sd4096, 16'sd0);
      // half gain: rounding of halves away from zero
      apply_setting(16'd128, 16'd0, 16'd0, 16'd0, 16'd0);
      send_request(16'sd1, 16'sd0);
      send_request(-16'sd1, 16'sd0);
      send_request(16'sd3, 16'sd0);
      send_request(16'sd8191, 16'sd0);      // rounds past the maximum
      // just under the maximum although it rounds to it
      apply_setting(16'd255, 16'd0, 16'd0, 16'd0, 16'd0);
      send_request(16'sd4111, 16'sd0);
      // zero clamp holds the integral at zero, so drive stays zero
      apply_setting(16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0);
      send_request(16'sh7FFF, 16'sh8000);
      send_request(16'sh8000, 16'sh7FFF);
      // writes to unused indexes must leave every register alone
      settle();
      for (int k = 1; k <= 3; k++)
         write_reg(pvc_pkg::REG_I_LIMIT + pvc_pkg::CSR_ADDR_W'(k), 16'($urandom));
      send_request(16'sd1000, -16'sd1000);
      apply_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_request(16'sd1, 16'sd0);
      send_request(16'sh8000, 16'sh7FFF);
   endtask

   task automatic test_register_settings();
      for (int s = 0; s < 6; s++) begin
         apply_setting(pick_gain(), pick_gain(), pick_gain(), pick_gain(),
                       $urandom_range(0, 1) ? 16'($urandom_range(0, 255)) : 16'($urandom));
         random_ticks(110);
      end
   endtask

   task automatic test_full_rate();
      apply_setting(16'd1667 + 16'($urandom_range(0, 200)), 16'd2458, 16'd12288, 16'd655,
                    16'd80);
      idle_on = 1'b0;
      random_ticks(100);
   endtask

   // result side: stall bursts while idling is on
   initial begin
      forever begin
         @(posedge clock);
         if (idle_on && !reset && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      drive_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.forward = rsp_tdata[0];
         got.magnitude = rsp_tdata[pvc_pkg::MAG_W:1];
         got.saturated = rsp_tdata[pvc_pkg::MAG_W + 1];
         if (pending_drive.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("unexpected response fwd=%0b mag=%0d sat=%0b",
                        got.forward, got.magnitude, got.saturated);
         end else begin
            want = pending_drive.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= REPORT_MAX)
                  $display({"drive mismatch: expected fwd=%0b mag=%0d sat=%0b,",
                            " got fwd=%0b mag=%0d sat=%0b"},
                           want.forward, want.magnitude, want.saturated,
                           got.forward, got.magnitude, got.saturated);
            end
         end
      end
   end

   // watchdog on handshake activity
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout: no request or response for %0d cycles", STALL_LIMIT);
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      gain_ff = pvc_pkg::RST_FF_GAIN;
      gain_p = pvc_pkg::RST_P_GAIN;
      gain_i = pvc_pkg::RST_I_GAIN;
      period_q16 = pvc_pkg::RST_PERIOD;
      limit_counts = pvc_pkg::RST_I_LIMIT;
      integral_q16 = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_drive_edges();
      test_register_settings();
      test_full_rate();
      settle();
      mismatches += pending_drive.size();
      $display("Ran %0d control ticks over %0d register settings, %0d of them saturated.",
               ticks_sent, settings_used, saturated_seen);
      $display("Mismatches: %0d", mismatches);
      if (mismatches == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
